/* design/ogru_pkg.sv */
package ogru_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_SCALE       = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ORIGIN_COL  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ORIGIN_ROW  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_COLS        = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROWS        = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_THRESHOLD   = 3'd5;

   localparam logic [6:0] OCC_UNKNOWN = 7'd50;
   localparam logic [6:0] OCC_FULL    = 7'd100;

   typedef enum logic [1:0] {
      MODE_POSE  = 2'd0,
      MODE_POINT = 2'd1,
      MODE_READ  = 2'd2,
      MODE_CLEAR = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      STAT_DONE      = 2'd0,
      STAT_NO_POSE   = 2'd1,
      STAT_OFF_GRID  = 2'd2,
      STAT_CELL_READ = 2'd3
   } rsp_status_type;

   typedef enum logic [4:0] {
      ST_CLEAR,
      ST_WIPE,
      ST_IDLE,
      ST_DISPATCH,
      ST_Q_T,
      ST_Q_M,
      ST_Q_S,
      ST_Q_D,
      ST_HIT_RD,
      ST_HIT_WR,
      ST_RAY_SET,
      ST_RAY_RD,
      ST_RAY_WR,
      ST_CELL_RD,
      ST_CELL_CHK,
      ST_OCC_DIV,
      ST_DONE
   } state_type;

   typedef enum logic [2:0] {
      MEM_IDLE,
      MEM_CLEAR,
      MEM_HIT_RD,
      MEM_HIT_WR,
      MEM_RAY_RD,
      MEM_RAY_WR,
      MEM_CELL_RD
   } mem_op_type;

   typedef enum logic [2:0] {
      RES_DONE_CELL,
      RES_DONE_EMPTY,
      RES_NO_POSE,
      RES_OFF_GRID,
      RES_OFF_ECHO,
      RES_CELL_UNKNOWN,
      RES_CELL_OCC
   } result_type;

   typedef struct packed {
      logic       req_ready;
      logic       sel_z;
      logic       t_load;
      logic       m_load;
      logic       div_quant;
      logic       div_occ;
      logic       q_store;
      logic       pose_load;
      logic       pose_drop;
      logic       ray_setup;
      logic       cell_latch;
      mem_op_type mem_op;
      logic       res_load;
      result_type res_kind;
   } cmd_type;

   typedef struct packed {
      mode_type mode;
      logic     pose_valid;
      logic     t_neg;
      logic     div_done;
      logic     q_ok;
      logic     ray_last;
      logic     vis_le_thr;
      logic     rd_off;
      logic     clr_last;
      logic     rsp_free;
   } dp_status_type;

endpackage

/* design/ogru_channels.sv */
interface ogru_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         mode;
   logic signed [23:0] world_x;
   logic signed [23:0] world_z;
   logic [7:0]         read_col;
   logic [7:0]         read_row;

   modport source (output valid, mode, world_x, world_z, read_col, read_row, input ready);
   modport sink (input valid, mode, world_x, world_z, read_col, read_row, output ready);
endinterface

interface ogru_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [7:0]  cell_col;
   logic [7:0]  cell_row;
   logic [6:0]  occupancy;
   logic [15:0] visit_count;
   logic [15:0] hit_count;

   modport source (output valid, status, cell_col, cell_row, occupancy, visit_count,
                   hit_count, input ready);
   modport sink (input valid, status, cell_col, cell_row, occupancy, visit_count,
                 hit_count, output ready);
endinterface

interface ogru_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [15:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

/* design/ogru_divider.sv */
module ogru_divider #(
   parameter int NUM_W = 47,
   parameter int DEN_W = 22
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             done,
   output logic [NUM_W-1:0] quo
);
   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [DEN_W:0]   rem_ff, rem_in, trial;
   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff[DEN_W-1:0], quo_ff[NUM_W-1]};
      if (start) begin
         rem_in  = '0;
         quo_in  = num;
         den_in  = den;
         cnt_in  = CNT_W'(NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = trial - {1'b0, den_ff};
            quo_in = {quo_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   assign done = done_ff;
   assign quo  = quo_ff;
endmodule

/* design/ogru_datapath.sv */
module ogru_datapath #(
   parameter int GRID_COLS  = 256,
   parameter int GRID_ROWS  = 256,
   parameter int COUNT_BITS = 16,
   parameter int FRAC_BITS  = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   ogru_req_if.sink               req_if,
   ogru_rsp_if.source             rsp_if,
   ogru_csr_if.sink               csr_if,
   input  ogru_pkg::cmd_type      cmd,
   output ogru_pkg::dp_status_type stat
);
   import ogru_pkg::*;

   localparam int COL_W    = $clog2(GRID_COLS);
   localparam int ROW_W    = $clog2(GRID_ROWS);
   localparam int GRID_MAX = (GRID_COLS > GRID_ROWS) ? GRID_COLS : GRID_ROWS;
   localparam int NG_W     = $clog2(GRID_MAX + 1);
   localparam int CL_W     = (NG_W > 9) ? NG_W : 9;
   localparam int RC_W     = (NG_W > 8) ? NG_W : 8;
   localparam int TH_W     = (COUNT_BITS > 16) ? COUNT_BITS : 16;
   localparam int T_W      = 31 + FRAC_BITS;
   localparam int P_W      = T_W - 1 + NG_W;
   localparam int QD_W     = NG_W + FRAC_BITS;
   localparam int ON_W     = COUNT_BITS + 7;
   localparam int DN_W     = (P_W > ON_W) ? P_W : ON_W;
   localparam int DD_W     = (QD_W > COUNT_BITS) ? QD_W : COUNT_BITS;
   localparam int AW       = COL_W + ROW_W;
   localparam int DEPTH    = 1 << AW;
   localparam int CW       = ((COL_W > ROW_W) ? COL_W : ROW_W) + 2;
   localparam int EW       = CW + 3;

   // configuration
   logic [4:0]         scale_ff;
   logic signed [15:0] org_col_ff, org_row_ff;
   logic [8:0]         cols_ff, rows_ff;
   logic [15:0]        thr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff   <= 5'd3;
         org_col_ff <= -16'sd128;
         org_row_ff <= -16'sd128;
         cols_ff    <= 9'd256;
         rows_ff    <= 9'd256;
         thr_ff     <= 16'd0;
      end else if (csr_if.valid) begin
         unique case (csr_if.index)
            CSR_SCALE:      scale_ff   <= csr_if.data[4:0];
            CSR_ORIGIN_COL: org_col_ff <= $signed(csr_if.data);
            CSR_ORIGIN_ROW: org_row_ff <= $signed(csr_if.data);
            CSR_COLS:       cols_ff    <= csr_if.data[8:0];
            CSR_ROWS:       rows_ff    <= csr_if.data[8:0];
            CSR_THRESHOLD:  thr_ff     <= csr_if.data;
            default: ;
         endcase
      end
   end

   assign csr_if.ready = 1'b1;

   logic [CL_W-1:0] cols_w, rows_w;
   logic [NG_W-1:0] n_cols, n_rows, n_sel;

   always_comb begin
      cols_w = CL_W'(cols_ff);
      rows_w = CL_W'(rows_ff);
      if (cols_w == '0)                     n_cols = NG_W'(1);
      else if (cols_w > CL_W'(GRID_COLS))   n_cols = NG_W'(GRID_COLS);
      else                                  n_cols = NG_W'(cols_w);
      if (rows_w == '0)                     n_rows = NG_W'(1);
      else if (rows_w > CL_W'(GRID_ROWS))   n_rows = NG_W'(GRID_ROWS);
      else                                  n_rows = NG_W'(rows_w);
   end

   // captured beat
   mode_type           mode_ff;
   logic signed [23:0] wx_ff, wz_ff;
   logic [7:0]         rcol_ff, rrow_ff;

   assign req_if.ready = cmd.req_ready;

   always_ff @(posedge clock) begin
      if (req_if.valid && cmd.req_ready) begin
         mode_ff <= mode_type'(req_if.mode);
         wx_ff   <= req_if.world_x;
         wz_ff   <= req_if.world_z;
         rcol_ff <= req_if.read_col;
         rrow_ff <= req_if.read_row;
      end
   end

   // quantizer
   logic signed [23:0]    w_sel;
   logic signed [15:0]    org_sel;
   logic signed [T_W-1:0] t_ff, t_in;
   logic [P_W-1:0]        m_ff;
   logic [COL_W-1:0]      qcol_ff;
   logic [ROW_W-1:0]      qrow_ff;
   logic [DN_W-1:0]       div_num, quo;
   logic [DD_W-1:0]       div_den;
   logic                  div_done;

   logic [COUNT_BITS-1:0] vis_rd_ff, hit_rd_ff, cell_vis_ff, cell_hit_ff;

   assign n_sel   = cmd.sel_z ? n_rows : n_cols;
   assign w_sel   = cmd.sel_z ? wz_ff : wx_ff;
   assign org_sel = cmd.sel_z ? org_row_ff : org_col_ff;
   assign t_in    = T_W'(w_sel) * T_W'($signed({1'b0, scale_ff}))
                  - (T_W'(org_sel) <<< FRAC_BITS);

   always_ff @(posedge clock) begin
      if (cmd.t_load) t_ff <= t_in;
      if (cmd.m_load) m_ff <= P_W'(t_ff[T_W-2:0]) * P_W'(n_sel - NG_W'(1));
      if (cmd.q_store && !cmd.sel_z) qcol_ff <= COL_W'(quo);
      if (cmd.q_store && cmd.sel_z)  qrow_ff <= ROW_W'(quo);
      if (cmd.cell_latch) begin
         cell_vis_ff <= vis_rd_ff;
         cell_hit_ff <= hit_rd_ff;
      end
   end

   assign div_num = cmd.div_occ ? DN_W'(hit_rd_ff) * DN_W'(OCC_FULL) : DN_W'(m_ff);
   assign div_den = cmd.div_occ ? DD_W'(vis_rd_ff) : (DD_W'(n_sel) << FRAC_BITS);

   ogru_divider #(.NUM_W(DN_W), .DEN_W(DD_W)) u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_quant || cmd.div_occ),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (quo)
   );

   // pose
   logic [COL_W-1:0] pose_col_ff;
   logic [ROW_W-1:0] pose_row_ff;
   logic             pose_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pose_col_ff   <= '0;
         pose_row_ff   <= '0;
         pose_valid_ff <= 1'b0;
      end else if (cmd.pose_load) begin
         pose_col_ff   <= qcol_ff;
         pose_row_ff   <= ROW_W'(quo);
         pose_valid_ff <= 1'b1;
      end else if (cmd.pose_drop) begin
         pose_valid_ff <= 1'b0;
      end
   end

   // line walker
   logic signed [CW-1:0] ax, ay, bx, by, adx, ady, sx0, sy0, sx1, sy1, x0, y0, x1, y1;
   logic                 steep;
   logic signed [CW-1:0] rx_ff, ry_ff, rxend_ff, rdx_ff, rdy_ff, ray_col, ray_row;
   logic signed [EW-1:0] err_ff, err_a;
   logic                 steep_ff, yneg_ff;
   logic [AW-1:0]        ray_addr;

   always_comb begin
      ax    = CW'(pose_col_ff);
      ay    = CW'(pose_row_ff);
      bx    = CW'(qcol_ff);
      by    = CW'(qrow_ff);
      adx   = (bx > ax) ? bx - ax : ax - bx;
      ady   = (by > ay) ? by - ay : ay - by;
      steep = ady > adx;
      sx0   = steep ? ay : ax;
      sy0   = steep ? ax : ay;
      sx1   = steep ? by : bx;
      sy1   = steep ? bx : by;
      if (sx0 > sx1) begin
         x0 = sx1; y0 = sy1; x1 = sx0; y1 = sy0;
      end else begin
         x0 = sx0; y0 = sy0; x1 = sx1; y1 = sy1;
      end
      err_a   = err_ff + (EW'(rdy_ff) <<< 1);
      ray_col = steep_ff ? ry_ff : rx_ff;
      ray_row = steep_ff ? rx_ff : ry_ff;
      ray_addr = {ray_row[ROW_W-1:0], ray_col[COL_W-1:0]};
   end

   always_ff @(posedge clock) begin
      if (cmd.ray_setup) begin
         rx_ff    <= x0;
         ry_ff    <= y0;
         rxend_ff <= x1;
         rdx_ff   <= x1 - x0;
         rdy_ff   <= (y1 > y0) ? y1 - y0 : y0 - y1;
         yneg_ff  <= !(y0 < y1);
         steep_ff <= steep;
         err_ff   <= '0;
      end else if (cmd.mem_op == MEM_RAY_WR) begin
         rx_ff <= rx_ff + CW'(1);
         if (err_a >= EW'(rdx_ff)) begin
            ry_ff  <= yneg_ff ? ry_ff - CW'(1) : ry_ff + CW'(1);
            err_ff <= err_a - (EW'(rdx_ff) <<< 1);
         end else begin
            err_ff <= err_a;
         end
      end
   end

   // counter stores
   logic [COUNT_BITS-1:0] visit_mem [DEPTH];
   logic [COUNT_BITS-1:0] hit_mem [DEPTH];
   logic [AW-1:0]         mem_addr, clr_cnt_ff;
   logic                  vis_we, hit_we;
   logic [COUNT_BITS-1:0] vis_wd, hit_wd;

   always_comb begin
      unique case (cmd.mem_op) inside
         MEM_CLEAR:              mem_addr = clr_cnt_ff;
         MEM_HIT_RD, MEM_HIT_WR: mem_addr = {qrow_ff, qcol_ff};
         MEM_RAY_RD, MEM_RAY_WR: mem_addr = ray_addr;
         MEM_CELL_RD:            mem_addr = {ROW_W'(rrow_ff), COL_W'(rcol_ff)};
         default:                mem_addr = '0;
      endcase
      vis_we = (cmd.mem_op == MEM_CLEAR) || (cmd.mem_op == MEM_RAY_WR);
      hit_we = (cmd.mem_op == MEM_CLEAR) || (cmd.mem_op == MEM_HIT_WR);
      if (cmd.mem_op == MEM_CLEAR) begin
         vis_wd = '0;
         hit_wd = '0;
      end else begin
         vis_wd = (&vis_rd_ff) ? vis_rd_ff : vis_rd_ff + COUNT_BITS'(1);
         hit_wd = (&hit_rd_ff) ? hit_rd_ff : hit_rd_ff + COUNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (vis_we) visit_mem[mem_addr] <= vis_wd;
      vis_rd_ff <= visit_mem[mem_addr];
   end

   always_ff @(posedge clock) begin
      if (hit_we) hit_mem[mem_addr] <= hit_wd;
      hit_rd_ff <= hit_mem[mem_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) clr_cnt_ff <= '0;
      else if (cmd.mem_op == MEM_CLEAR) clr_cnt_ff <= clr_cnt_ff + AW'(1);
   end

   // result register
   logic           rsp_valid_ff;
   rsp_status_type rsp_status_ff;
   logic [7:0]     rsp_col_ff, rsp_row_ff;
   logic [6:0]     rsp_occ_ff, occ_calc;
   logic [15:0]    rsp_vis_ff, rsp_hit_ff;

   assign occ_calc = (quo > DN_W'(OCC_FULL)) ? OCC_FULL : quo[6:0];

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (cmd.res_load) rsp_valid_ff <= 1'b1;
      else if (rsp_if.ready) rsp_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (cmd.res_load) begin
         rsp_col_ff <= '0;
         rsp_row_ff <= '0;
         rsp_occ_ff <= '0;
         rsp_vis_ff <= '0;
         rsp_hit_ff <= '0;
         unique case (cmd.res_kind)
            RES_DONE_CELL: begin
               rsp_status_ff <= STAT_DONE;
               rsp_col_ff    <= 8'(qcol_ff);
               rsp_row_ff    <= 8'(qrow_ff);
            end
            RES_NO_POSE:  rsp_status_ff <= STAT_NO_POSE;
            RES_OFF_GRID: rsp_status_ff <= STAT_OFF_GRID;
            RES_OFF_ECHO: begin
               rsp_status_ff <= STAT_OFF_GRID;
               rsp_col_ff    <= rcol_ff;
               rsp_row_ff    <= rrow_ff;
            end
            RES_CELL_UNKNOWN, RES_CELL_OCC: begin
               rsp_status_ff <= STAT_CELL_READ;
               rsp_col_ff    <= rcol_ff;
               rsp_row_ff    <= rrow_ff;
               rsp_occ_ff    <= (cmd.res_kind == RES_CELL_OCC) ? occ_calc : OCC_UNKNOWN;
               rsp_vis_ff    <= 16'(cell_vis_ff);
               rsp_hit_ff    <= 16'(cell_hit_ff);
            end
            default: rsp_status_ff <= STAT_DONE;
         endcase
      end
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.status      = rsp_status_ff;
   assign rsp_if.cell_col    = rsp_col_ff;
   assign rsp_if.cell_row    = rsp_row_ff;
   assign rsp_if.occupancy   = rsp_occ_ff;
   assign rsp_if.visit_count = rsp_vis_ff;
   assign rsp_if.hit_count   = rsp_hit_ff;

   // status to controller
   assign stat.mode       = mode_ff;
   assign stat.pose_valid = pose_valid_ff;
   assign stat.t_neg      = t_ff[T_W-1];
   assign stat.div_done   = div_done;
   assign stat.q_ok       = quo < DN_W'(n_sel);
   assign stat.ray_last   = rx_ff == rxend_ff;
   assign stat.vis_le_thr = TH_W'(vis_rd_ff) <= TH_W'(thr_ff);
   assign stat.rd_off     = (RC_W'(rcol_ff) >= RC_W'(n_cols)) || (RC_W'(rrow_ff) >= RC_W'(n_rows));
   assign stat.clr_last   = &clr_cnt_ff;
   assign stat.rsp_free   = !rsp_valid_ff || rsp_if.ready;
endmodule

/* design/ogru_controller.sv */
module ogru_controller (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  ogru_pkg::dp_status_type stat,
   output ogru_pkg::cmd_type       cmd
);
   import ogru_pkg::*;

   state_type  state_ff, state_in;
   logic       axis_ff, axis_in;
   result_type kind_ff, kind_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         axis_ff  <= 1'b0;
         kind_ff  <= RES_DONE_EMPTY;
      end else begin
         state_ff <= state_in;
         axis_ff  <= axis_in;
         kind_ff  <= kind_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      axis_in      = axis_ff;
      kind_in      = kind_ff;
      cmd          = '0;
      cmd.sel_z    = axis_ff;
      cmd.mem_op   = MEM_IDLE;
      cmd.res_kind = kind_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.mem_op = MEM_CLEAR;
            if (stat.clr_last) state_in = ST_IDLE;
         end
         ST_WIPE: begin
            cmd.mem_op = MEM_CLEAR;
            if (stat.clr_last) state_in = ST_DONE;
         end
         ST_IDLE: begin
            cmd.req_ready = 1'b1;
            axis_in       = 1'b0;
            if (req_valid) state_in = ST_DISPATCH;
         end
         ST_DISPATCH: begin
            unique case (stat.mode)
               MODE_POSE: state_in = ST_Q_T;
               MODE_POINT: begin
                  if (stat.pose_valid) begin
                     state_in = ST_Q_T;
                  end else begin
                     kind_in  = RES_NO_POSE;
                     state_in = ST_DONE;
                  end
               end
               MODE_READ: begin
                  if (stat.rd_off) begin
                     kind_in  = RES_OFF_ECHO;
                     state_in = ST_DONE;
                  end else begin
                     state_in = ST_CELL_RD;
                  end
               end
               default: begin
                  kind_in  = RES_DONE_EMPTY;
                  state_in = ST_WIPE;
               end
            endcase
         end
         ST_Q_T: begin
            cmd.t_load = 1'b1;
            state_in   = ST_Q_M;
         end
         ST_Q_M: begin
            if (stat.t_neg) begin
               cmd.pose_drop = stat.mode == MODE_POSE;
               kind_in       = RES_OFF_GRID;
               state_in      = ST_DONE;
            end else begin
               cmd.m_load = 1'b1;
               state_in   = ST_Q_S;
            end
         end
         ST_Q_S: begin
            cmd.div_quant = 1'b1;
            state_in      = ST_Q_D;
         end
         ST_Q_D: begin
            if (stat.div_done) begin
               if (!stat.q_ok) begin
                  cmd.pose_drop = stat.mode == MODE_POSE;
                  kind_in       = RES_OFF_GRID;
                  state_in      = ST_DONE;
               end else begin
                  cmd.q_store = 1'b1;
                  if (!axis_ff) begin
                     axis_in  = 1'b1;
                     state_in = ST_Q_T;
                  end else if (stat.mode == MODE_POSE) begin
                     cmd.pose_load = 1'b1;
                     kind_in       = RES_DONE_CELL;
                     state_in      = ST_DONE;
                  end else begin
                     state_in = ST_HIT_RD;
                  end
               end
            end
         end
         ST_HIT_RD: begin
            cmd.mem_op = MEM_HIT_RD;
            state_in   = ST_HIT_WR;
         end
         ST_HIT_WR: begin
            cmd.mem_op = MEM_HIT_WR;
            state_in   = ST_RAY_SET;
         end
         ST_RAY_SET: begin
            cmd.ray_setup = 1'b1;
            state_in      = ST_RAY_RD;
         end
         ST_RAY_RD: begin
            cmd.mem_op = MEM_RAY_RD;
            state_in   = ST_RAY_WR;
         end
         ST_RAY_WR: begin
            cmd.mem_op = MEM_RAY_WR;
            if (stat.ray_last) begin
               kind_in  = RES_DONE_CELL;
               state_in = ST_DONE;
            end else begin
               state_in = ST_RAY_RD;
            end
         end
         ST_CELL_RD: begin
            cmd.mem_op = MEM_CELL_RD;
            state_in   = ST_CELL_CHK;
         end
         ST_CELL_CHK: begin
            cmd.cell_latch = 1'b1;
            if (stat.vis_le_thr) begin
               kind_in  = RES_CELL_UNKNOWN;
               state_in = ST_DONE;
            end else begin
               cmd.div_occ = 1'b1;
               state_in    = ST_OCC_DIV;
            end
         end
         ST_OCC_DIV: begin
            if (stat.div_done) begin
               kind_in  = RES_CELL_OCC;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (stat.rsp_free) begin
               cmd.res_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end
endmodule

/* design/occupancy_grid_ray_update_core.sv */
// Occupancy grid ray update core.
// req_if carries one command beat (mode, world_x, world_z, read_col, read_row);
// rsp_if returns exactly one result beat per command; csr_if writes the six
// configuration registers by index and is always ready.
// One command is worked at a time; req_if.ready is high only while idle.
// Each quantized axis runs a multiply then the shared restoring divider, one
// quotient bit a cycle. Map point adds a visit counter read-modify-write for
// each ray cell; read cell adds the occupancy division when the visit count
// is above the threshold.
// Clear grid: one counter entry per cycle over all 2^(log2 cols + log2 rows)
// entries (65536 with the default grid).
// Reset runs the same clearing pass; configuration writes are taken meanwhile
// but no command is accepted until it ends.
// The result sits in an output register; while rsp_if is stalled the finished
// command waits for that register to free before the next one is taken.
module occupancy_grid_ray_update_core #(
   parameter int GRID_COLS  = 256,
   parameter int GRID_ROWS  = 256,
   parameter int COUNT_BITS = 16,
   parameter int FRAC_BITS  = 8
) (
   input  logic       clock,
   input  logic       reset,
   ogru_req_if.sink   req_if,
   ogru_rsp_if.source rsp_if,
   ogru_csr_if.sink   csr_if
);
   import ogru_pkg::*;

   cmd_type       cmd;
   dp_status_type stat;

   ogru_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .stat      (stat),
      .cmd       (cmd)
   );

   ogru_datapath #(
      .GRID_COLS  (GRID_COLS),
      .GRID_ROWS  (GRID_ROWS),
      .COUNT_BITS (COUNT_BITS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_dp (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if),
      .cmd    (cmd),
      .stat   (stat)
   );

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready) |=> !req_if.ready)
      else $error("command accepted while another is in flight");

   a_result_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd.res_load |-> stat.rsp_free)
      else $error("result loaded over an untaken beat");

   a_reset_clears_first: assert property (@(posedge clock)
      reset |=> !req_if.ready)
      else $error("ready during clearing pass after reset");

   a_rmw_order: assert property (@(posedge clock) disable iff (reset)
      (cmd.mem_op == MEM_RAY_WR) |-> ($past(cmd.mem_op) == MEM_RAY_RD))
      else $error("visit write without preceding read");
endmodule

/* sim/tb_occupancy_grid_ray_update_core.sv */
module tb_occupancy_grid_ray_update_core;
   timeunit 1ns;
   timeprecision 1ps;

   import ogru_pkg::*;

   localparam int NCOLS     = 256;
   localparam int NROWS     = 256;
   localparam int CNT_MAX   = 65535;
   localparam int PHASES    = 6;
   localparam int PHASE_LEN = 190;

   typedef struct {
      mode_type          mode;
      logic signed [23:0] wx;
      logic signed [23:0] wz;
      logic [7:0]        rc;
      logic [7:0]        rr;
   } req_item_type;

   typedef struct {
      rsp_status_type status;
      logic [7:0]     col;
      logic [7:0]     row;
      logic [6:0]     occ;
      logic [15:0]    vis;
      logic [15:0]    hit;
   } rsp_item_type;

   typedef struct {
      req_item_type cmd;
      bit           typed;
      rsp_item_type rsp;
   } dir_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ogru_req_if req_if ();
   ogru_rsp_if rsp_if ();
   ogru_csr_if csr_if ();

   occupancy_grid_ray_update_core dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   always #6 clock = ~clock;

   // predictor state
   int unsigned visits [NCOLS*NROWS];
   int unsigned hits   [NCOLS*NROWS];
   int unsigned pose_c, pose_r;
   bit          pose_ok;
   int unsigned scale_q;
   int          org_c, org_r;
   int unsigned cols_q, rows_q, thr_q;
   int unsigned last_c, last_r;

   rsp_item_type pending_rsp [$];
   dir_row_type  dir_tab [$];
   int           mismatches = 0;
   int           n_items = 0, n_clears = 0, n_reads = 0, n_points = 0;
   int           send_idle = 0, recv_idle = 0;

   function automatic int unsigned clamp_n(int unsigned v, int unsigned hi);
      if (v < 1) return 1;
      return (v > hi) ? hi : v;
   endfunction

   function automatic bit quant(longint w, int org, int unsigned n, output int unsigned q_cell);
      longint t;
      longint q;
      t = w * longint'(scale_q) - longint'(org) * 256;
      q_cell = 0;
      if (t < 0) return 0;
      q = (t * longint'(n - 1)) / (longint'(n) * 256);
      if (q >= n) return 0;
      q_cell = 32'(q);
      return 1;
   endfunction

   function automatic void bump_visit(int c, int r);
      int i;
      if (c < 0 || r < 0 || c >= NCOLS || r >= NROWS) return;
      i = r * NCOLS + c;
      if (visits[i] < CNT_MAX) visits[i]++;
   endfunction

   function automatic void walk_ray(int ax, int ay, int bx, int by);
      int  adx, ady, t, dx, dy, y, ystep, x, err;
      bit  steep;
      adx = (bx > ax) ? bx - ax : ax - bx;
      ady = (by > ay) ? by - ay : ay - by;
      steep = ady > adx;
      if (steep) begin
         t = ax; ax = ay; ay = t;
         t = bx; bx = by; by = t;
      end
      if (ax > bx) begin
         t = ax; ax = bx; bx = t;
         t = ay; ay = by; by = t;
      end
      dx = bx - ax;
      dy = (by > ay) ? by - ay : ay - by;
      ystep = (ay < by) ? 1 : -1;
      y = ay;
      err = 0;
      for (x = ax; x <= bx; x++) begin
         if (steep) bump_visit(y, x);
         else bump_visit(x, y);
         err += 2 * dy;
         if (err >= dx) begin
            y += ystep;
            err -= 2 * dx;
         end
      end
   endfunction

   function automatic rsp_item_type grid_update(req_item_type cmd);
      rsp_item_type o;
      int unsigned  nc, nr, c, r, i, v, h;
      longint       p;
      bit           okc, okr;
      o = '{STAT_DONE, 8'd0, 8'd0, 7'd0, 16'd0, 16'd0};
      nc = clamp_n(cols_q, NCOLS);
      nr = clamp_n(rows_q, NROWS);
      case (cmd.mode)
         MODE_POSE: begin
            okc = quant(longint'(cmd.wx), org_c, nc, c);
            okr = quant(longint'(cmd.wz), org_r, nr, r);
            if (okc && okr) begin
               pose_c = c; pose_r = r; pose_ok = 1;
               o.col = c; o.row = r;
               last_c = c; last_r = r;
            end else begin
               pose_ok = 0;
               o.status = STAT_OFF_GRID;
            end
         end
         MODE_POINT: begin
            okc = quant(longint'(cmd.wx), org_c, nc, c);
            okr = quant(longint'(cmd.wz), org_r, nr, r);
            if (!pose_ok) o.status = STAT_NO_POSE;
            else if (okc && okr) begin
               i = r * NCOLS + c;
               if (hits[i] < CNT_MAX) hits[i]++;
               walk_ray(pose_c, pose_r, c, r);
               o.col = c; o.row = r;
               last_c = c; last_r = r;
            end else o.status = STAT_OFF_GRID;
         end
         MODE_READ: begin
            o.col = cmd.rc; o.row = cmd.rr;
            if (cmd.rc >= nc || cmd.rr >= nr) o.status = STAT_OFF_GRID;
            else begin
               i = cmd.rr * NCOLS + cmd.rc;
               v = visits[i]; h = hits[i];
               o.status = STAT_CELL_READ;
               o.vis = v; o.hit = h;
               if (v <= thr_q) o.occ = OCC_UNKNOWN;
               else begin
                  p = (longint'(h) * 100) / longint'(v);
                  o.occ = (p > 100) ? OCC_FULL : p;
               end
            end
         end
         default: begin
            foreach (visits[k]) begin
               visits[k] = 0;
               hits[k] = 0;
            end
         end
      endcase
      return o;
   endfunction

   function automatic void add_row(mode_type m, int wx, int wz, int rc, int rr, bit typed,
                                   rsp_status_type st = STAT_DONE, int c = 0, int r = 0,
                                   int occ = 0, int v = 0, int h = 0);
      dir_row_type d;
      d.cmd = '{m, wx[23:0], wz[23:0], rc[7:0], rr[7:0]};
      d.typed = typed;
      d.rsp = '{st, c[7:0], r[7:0], occ[6:0], v[15:0], h[15:0]};
      dir_tab.push_back(d);
   endfunction

   task automatic send_cmd(req_item_type cmd, bit typed, rsp_item_type typed_rsp);
      rsp_item_type pr;
      if ($urandom_range(99) < send_idle) begin
         req_if.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle);
      end
      req_if.valid    <= 1'b1;
      req_if.mode     <= cmd.mode;
      req_if.world_x  <= cmd.wx;
      req_if.world_z  <= cmd.wz;
      req_if.read_col <= cmd.rc;
      req_if.read_row <= cmd.rr;
      do @(posedge clock); while (!req_if.ready);
      pr = grid_update(cmd);
      pending_rsp.push_back(typed ? typed_rsp : pr);
      n_items++;
      if (cmd.mode == MODE_CLEAR) n_clears++;
      if (cmd.mode == MODE_READ) n_reads++;
      if (cmd.mode == MODE_POINT) n_points++;
   endtask

   task automatic write_regs(int unsigned sc, int oc, int orr, int unsigned nc,
                             int unsigned nr, int unsigned th);
      logic [15:0] vals [6];
      vals = '{sc[15:0], oc[15:0], orr[15:0], nc[15:0], nr[15:0], th[15:0]};
      for (int i = 0; i < 6; i++) begin
         csr_if.valid <= 1'b1;
         csr_if.index <= i[2:0];
         csr_if.data  <= vals[i];
         do @(posedge clock); while (!csr_if.ready);
      end
      csr_if.valid <= 1'b0;
      scale_q = sc & 5'h1F;
      org_c = $signed(vals[CSR_ORIGIN_COL]);
      org_r = $signed(vals[CSR_ORIGIN_ROW]);
      cols_q = nc & 9'h1FF;
      rows_q = nr & 9'h1FF;
      thr_q = th & 16'hFFFF;
   endtask

   function automatic logic [23:0] pick_coord(int org, int unsigned n);
      longint tgt, w;
      if (scale_q == 0 || $urandom_range(9) == 0) return $urandom;
      tgt = longint'($urandom_range(n * 256 + 64)) - 16;
      w = (tgt + longint'(org) * 256) / longint'(scale_q);
      if (w > 8388607) w = 8388607;
      if (w < -8388608) w = -8388608;
      return w[23:0];
   endfunction

   function automatic req_item_type rand_cmd();
      req_item_type c;
      int unsigned  k, nc, nr;
      nc = clamp_n(cols_q, NCOLS);
      nr = clamp_n(rows_q, NROWS);
      k = $urandom_range(999);
      c.wx = pick_coord(org_c, nc);
      c.wz = pick_coord(org_r, nr);
      c.rc = $urandom;
      c.rr = $urandom;
      if (k < 2) c.mode = MODE_CLEAR;
      else if (k < 110) c.mode = MODE_POSE;
      else if (k < 800) c.mode = MODE_POINT;
      else begin
         c.mode = MODE_READ;
         k = $urandom_range(9);
         if (k < 5) begin
            c.rc = last_c; c.rr = last_r;
         end else if (k < 7) begin
            c.rc = pose_c; c.rr = pose_r;
         end else if (k < 9) begin
            c.rc = $urandom_range(nc - 1); c.rr = $urandom_range(nr - 1);
         end
      end
      return c;
   endfunction

   always @(posedge clock) begin
      rsp_item_type e;
      rsp_if.ready <= ($urandom_range(99) >= recv_idle);
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result beat, status %0d", rsp_if.status);
         end else begin
            e = pending_rsp.pop_front();
            if (rsp_if.status !== e.status || rsp_if.cell_col !== e.col ||
                rsp_if.cell_row !== e.row || rsp_if.occupancy !== e.occ ||
                rsp_if.visit_count !== e.vis || rsp_if.hit_count !== e.hit) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"mismatch: exp st=%0d c=%0d r=%0d occ=%0d v=%0d h=%0d, ",
                            "got st=%0d c=%0d r=%0d occ=%0d v=%0d h=%0d"},
                           e.status, e.col, e.row, e.occ, e.vis, e.hit,
                           rsp_if.status, rsp_if.cell_col, rsp_if.cell_row,
                           rsp_if.occupancy, rsp_if.visit_count, rsp_if.hit_count);
            end
         end
      end
   end

   initial begin
      #100_000_000;
      $display("TEST FAILED");
      $finish;
   end

   initial begin
      rsp_item_type none;
      int unsigned  cfg [PHASES][6];
      none = '{STAT_DONE, 8'd0, 8'd0, 7'd0, 16'd0, 16'd0};
      cfg[0] = '{1, 32'hFFFF8000, 32'hFFFF8000, 1, 256, 65535};
      cfg[1] = '{16, 32767, 0, 17, 200, 2};
      cfg[2] = '{0, -10, -5, 0, 511, 1};
      cfg[3] = '{31, -200, 100, 64, 64, 3};
      cfg[4] = '{5, -1000, -1000, 256, 128, 0};
      cfg[5] = '{3, -128, -128, 256, 256, 0};

      req_if.valid = 0; req_if.mode = MODE_POSE; req_if.world_x = 0; req_if.world_z = 0;
      req_if.read_col = 0; req_if.read_row = 0;
      rsp_if.ready = 0;
      csr_if.valid = 0; csr_if.index = CSR_SCALE; csr_if.data = 0;

      foreach (visits[k]) begin
         visits[k] = 0;
         hits[k] = 0;
      end
      pose_c = 0; pose_r = 0; pose_ok = 0; last_c = 0; last_r = 0;
      scale_q = 3; org_c = -128; org_r = -128; cols_q = 256; rows_q = 256; thr_q = 0;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      add_row(MODE_POINT, 0, 0, 0, 0, 1, STAT_NO_POSE);
      add_row(MODE_READ, 0, 0, 0, 0, 1, STAT_CELL_READ, 0, 0, 50);
      add_row(MODE_READ, 0, 0, 255, 255, 1, STAT_CELL_READ, 255, 255, 50);
      add_row(MODE_POSE, -8388608, 0, 0, 0, 1, STAT_OFF_GRID);
      add_row(MODE_POSE, 8388607, 8388607, 0, 0, 1, STAT_OFF_GRID);
      add_row(MODE_POINT, 0, 0, 0, 0, 1, STAT_NO_POSE);
      add_row(MODE_POSE, 0, 0, 0, 0, 1, STAT_DONE, 127, 127);
      add_row(MODE_POINT, 0, 0, 0, 0, 1, STAT_DONE, 127, 127);
      add_row(MODE_READ, 0, 0, 127, 127, 1, STAT_CELL_READ, 127, 127, 100, 1, 1);
      add_row(MODE_POINT, 8388607, 0, 0, 0, 1, STAT_OFF_GRID);
      add_row(MODE_POINT, -8388608, 0, 0, 0, 1, STAT_OFF_GRID);
      add_row(MODE_POINT, 11008, 11008, 0, 0, 0);
      add_row(MODE_POINT, -10922, -10922, 0, 0, 0);
      add_row(MODE_POINT, 11008, -10922, 0, 0, 0);
      add_row(MODE_POINT, 0, 11008, 0, 0, 0);
      add_row(MODE_READ, 0, 0, 255, 127, 0);
      add_row(MODE_READ, 0, 0, 0, 0, 0);
      add_row(MODE_READ, 0, 0, 127, 127, 0);
      add_row(MODE_POSE, 11008, 11008, 0, 0, 0);
      add_row(MODE_POINT, -10922, -10922, 0, 0, 0);
      add_row(MODE_READ, 0, 0, 200, 200, 0);
      add_row(MODE_CLEAR, 0, 0, 0, 0, 1, STAT_DONE);
      add_row(MODE_READ, 0, 0, 127, 127, 1, STAT_CELL_READ, 127, 127, 50);
      add_row(MODE_POINT, 100, -100, 0, 0, 0);

      foreach (dir_tab[i]) send_cmd(dir_tab[i].cmd, dir_tab[i].typed, dir_tab[i].rsp);

      for (int ph = 0; ph < PHASES; ph++) begin
         req_if.valid <= 1'b0;
         wait (pending_rsp.size() == 0);
         @(posedge clock);
         write_regs(cfg[ph][0], cfg[ph][1], cfg[ph][2], cfg[ph][3], cfg[ph][4], cfg[ph][5]);
         case (ph / 2)
            0: begin send_idle = 12; recv_idle = 85; end
            1: begin send_idle = 85; recv_idle = 12; end
            default: begin send_idle = 0; recv_idle = 0; end
         endcase
         // open each phase with a pose so points get through
         send_cmd('{MODE_POSE, pick_coord(org_c, clamp_n(cols_q, NCOLS)),
                    pick_coord(org_r, clamp_n(rows_q, NROWS)), 8'd0, 8'd0}, 0, none);
         repeat (PHASE_LEN) send_cmd(rand_cmd(), 0, none);
      end
      req_if.valid <= 1'b0;
      wait (pending_rsp.size() == 0);
      repeat (100) @(posedge clock);

      $display("beats sent: %0d (points %0d, reads %0d, clears %0d)",
               n_items, n_points, n_reads, n_clears);
      $display("config sets: %0d, mismatches: %0d", PHASES, mismatches);
      if (mismatches == 0 && pending_rsp.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end
endmodule
